// ===== design/fgk_pkg.sv =====
// Shared constants, helper functions and the bit-token struct of the FGK encoder.
// No dependencies; every other design file imports it, except fgk_rsp_if.
`default_nettype none
package fgk_pkg;
   localparam int ALPHABET_SIZE = 256;
   localparam int NODE_COUNT    = 513;
   localparam int WEIGHT_WIDTH  = 32;
   localparam int PATH_DEPTH    = 256;
   localparam int SYM_W         = 8;
   localparam int NODE_W        = $clog2(NODE_COUNT);
   localparam int PATH_W        = $clog2(PATH_DEPTH);

   localparam logic [NODE_W-1:0]       ROOT_NODE  = '0;
   localparam logic [NODE_W-1:0]       ESC_INIT   = NODE_W'(1);
   localparam logic [NODE_W-1:0]       NFREE_INIT = NODE_W'(2);
   localparam logic [NODE_W-1:0]       TOP_ORDER  = NODE_W'(NODE_COUNT - 1);
   localparam logic [NODE_W:0]         NODE_LIM   = (NODE_W+1)'(NODE_COUNT);
   localparam logic [SYM_W:0]          ALPHA_LIM  = (SYM_W+1)'(ALPHABET_SIZE);
   localparam logic [PATH_W:0]         PATH_LIM   = (PATH_W+1)'(PATH_DEPTH);
   localparam logic [WEIGHT_WIDTH-1:0] WMAX       = '1;

   // one bit (or the end-of-transaction marker) from the tree walker to the packer
   typedef struct packed {
      logic valid;
      logic bit_val;
      logic fin;
      logic flush;
      logic ovf;
   } fgk_tok_type;

   function automatic logic node_bad(input logic [NODE_W-1:0] n);
      return {1'b0, n} >= NODE_LIM;
   endfunction
endpackage
`default_nettype wire

// ===== design/fgk_req_if.sv =====
// Input channel interface: valid/ready plus symbol byte and end flag.
// Depends on fgk_pkg for the symbol width.
`default_nettype none
interface fgk_req_if;
   import fgk_pkg::*;
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] in_byte;
   logic             is_end;
   modport source (output valid, in_byte, is_end, input ready);
   modport sink   (input valid, in_byte, is_end, output ready);
endinterface
`default_nettype wire

// ===== design/fgk_rsp_if.sv =====
// Result channel interface: valid/ready plus packed byte and flags.
// No dependencies.
`default_nettype none
interface fgk_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last;
   logic       stream_done;
   logic       overflow;
   modport source (output valid, out_byte, last, stream_done, overflow, input ready);
   modport sink   (input valid, out_byte, last, stream_done, overflow, output ready);
endinterface
`default_nettype wire

// ===== design/adaptive_huffman_encoder_top.sv =====
// FGK adaptive Huffman encoder, 8-bit symbols; top level.
// Per transaction: path walk up the tree; then the update, level by level, with an
//   equal-weight scan and a swap where one is found; then code bits and raw bits to
//   emit, which the result channel can hold off.
// Throughput: one transaction at a time, bounded by the node memories (one read and
//   one write port each) walked by the sequencer.
// Reset (synchronous, active high): tree holds only root and escape, nothing pending.
// Depends on fgk_pkg, fgk_req_if, fgk_rsp_if, fgk_tree, fgk_packer.
`default_nettype none
module adaptive_huffman_encoder_top
   import fgk_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   fgk_req_if.sink   req,
   fgk_rsp_if.source rsp
);
   fgk_tok_type tok;
   logic        tok_ready;

   // tree walk, split and FGK update; streams code bits, raw symbol bits for a new symbol, then an end marker
   fgk_tree u_tree (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .tok       (tok),
      .tok_ready (tok_ready)
   );

   // byte packing, flush padding and last-byte flagging
   fgk_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .tok       (tok),
      .tok_ready (tok_ready),
      .rsp       (rsp)
   );
endmodule
`default_nettype wire

// ===== design/fgk_tree.sv =====
// Tree sequencer: node memories, path walk, escape split, FGK update, bit emission.
// Depends on fgk_pkg and fgk_req_if.
`default_nettype none
module fgk_tree
   import fgk_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   fgk_req_if.sink    req,
   output fgk_tok_type tok,
   input  wire logic  tok_ready
);
   typedef enum logic [4:0] {
      S_IDLE, S_LEAF, S_EORD, S_WP, S_WP2, S_WR,
      S_SP0, S_SP1, S_SP2, S_SP3, S_SP4, S_F1, S_F2,
      S_UST, S_U0, S_U1, S_SC, S_SC2, S_SC3, S_DEC,
      S_SW0, S_SW1, S_SW2, S_SW3, S_SW4, S_INC,
      S_ER, S_EW, S_EB, S_RAW, S_FIN
   } state_type;
   typedef enum logic [1:0] {M_OLD, M_NEW, M_END, M_FIRST} mode_type;

   // node memories
   logic [WEIGHT_WIDTH-1:0] wt_mem   [NODE_COUNT];
   logic [NODE_W-1:0]       par_mem  [NODE_COUNT];
   logic [NODE_W-1:0]       lft_mem  [NODE_COUNT];
   logic [NODE_W-1:0]       rgt_mem  [NODE_COUNT];
   logic [NODE_W-1:0]       nord_mem [NODE_COUNT];
   logic [NODE_W-1:0]       o2n_mem  [NODE_COUNT];
   logic [NODE_W-1:0]       leaf_mem [ALPHABET_SIZE];
   logic                    stk_mem  [PATH_DEPTH];

   logic                    wt_we, par_we, lft_we, rgt_we, nord_we, o2n_we, leaf_we, stk_we;
   logic [NODE_W-1:0]       wt_wa, par_wa, lft_wa, rgt_wa, nord_wa, o2n_wa;
   logic [NODE_W-1:0]       wt_ra, par_ra, lft_ra, rgt_ra, nord_ra, o2n_ra;
   logic [WEIGHT_WIDTH-1:0] wt_wd, wt_q;
   logic [NODE_W-1:0]       par_wd, lft_wd, rgt_wd, nord_wd, o2n_wd, leaf_wd;
   logic [NODE_W-1:0]       par_q, lft_q, rgt_q, nord_q, o2n_q, leaf_q;
   logic [SYM_W-1:0]        leaf_wa, leaf_ra;
   logic [PATH_W-1:0]       stk_wa;
   logic                    stk_wd, stk_q;

   state_type               st_ff;
   mode_type                mode_ff;
   logic [SYM_W-1:0]        sym_ff;
   logic                    end_ff;
   logic [NODE_W-1:0]       node_ff, pnode_ff, lf_ff, eord_ff, ord_ff, pn_ff, i_ff;
   logic [NODE_W-1:0]       best_ff, bnode_ff, mnode_ff, pb_ff, ra_ff, la_ff, rb_ff;
   logic [PATH_W:0]         depth_ff;
   logic [NODE_W:0]         guard_ff;
   logic [2:0]              k_ff;
   logic [WEIGHT_WIDTH-1:0] w_ff, rootw_ff;
   logic [NODE_W-1:0]       esc_ff, nfree_ff;
   logic                    first_ff;
   logic [ALPHABET_SIZE-1:0] seen_ff;

   logic [NODE_W-1:0]       aux, leaf_n;
   logic                    raw_mode;

   assign aux      = nfree_ff;
   assign leaf_n   = nfree_ff + NODE_W'(1);
   assign raw_mode = (mode_ff == M_NEW) || (mode_ff == M_FIRST);
   assign req.ready = (st_ff == S_IDLE);

   always_comb begin
      tok         = '0;
      tok.ovf     = (rootw_ff == WMAX);
      tok.flush   = end_ff;
      tok.valid   = (st_ff == S_EB) || (st_ff == S_RAW) || (st_ff == S_FIN);
      tok.fin     = (st_ff == S_FIN);
      tok.bit_val = (st_ff == S_EB) ? stk_q : sym_ff[k_ff];
   end

   // memory addresses and write strobes
   always_comb begin
      wt_we = 1'b0; par_we = 1'b0; lft_we = 1'b0; rgt_we = 1'b0;
      nord_we = 1'b0; o2n_we = 1'b0; leaf_we = 1'b0; stk_we = 1'b0;
      wt_wa = '0; par_wa = '0; lft_wa = '0; rgt_wa = '0; nord_wa = '0; o2n_wa = '0;
      wt_wd = '0; par_wd = '0; lft_wd = '0; rgt_wd = '0; nord_wd = '0; o2n_wd = '0;
      leaf_wa = sym_ff; leaf_wd = '0; stk_wa = depth_ff[PATH_W-1:0]; stk_wd = 1'b0;
      wt_ra = '0; par_ra = '0; lft_ra = '0; rgt_ra = '0; nord_ra = '0; o2n_ra = '0;
      leaf_ra = req.in_byte;
      unique case (st_ff)
         S_IDLE: nord_ra = esc_ff;
         S_WP:   par_ra = node_ff;
         S_WP2:  rgt_ra = par_q;
         S_WR: begin
            stk_we = 1'b1;
            stk_wd = (rgt_q == node_ff);
         end
         S_SP0:  par_ra = esc_ff;
         S_SP1:  rgt_ra = par_q;
         S_SP2: begin
            if (rgt_q == esc_ff) begin
               rgt_we = 1'b1; rgt_wa = pnode_ff; rgt_wd = aux;
            end else begin
               lft_we = 1'b1; lft_wa = pnode_ff; lft_wd = aux;
            end
            par_we = 1'b1;  par_wa = aux;  par_wd = pnode_ff;
            wt_we = 1'b1;   wt_wa = aux;   wt_wd = '0;
            nord_we = 1'b1; nord_wa = aux; nord_wd = eord_ff;
            o2n_we = 1'b1;  o2n_wa = eord_ff; o2n_wd = aux;
         end
         S_SP3: begin
            lft_we = 1'b1;  lft_wa = aux;    lft_wd = esc_ff;
            rgt_we = 1'b1;  rgt_wa = aux;    rgt_wd = leaf_n;
            par_we = 1'b1;  par_wa = leaf_n; par_wd = aux;
            wt_we = 1'b1;   wt_wa = leaf_n;  wt_wd = WEIGHT_WIDTH'(1);
            nord_we = 1'b1; nord_wa = leaf_n; nord_wd = eord_ff - NODE_W'(1);
            o2n_we = 1'b1;  o2n_wa = eord_ff - NODE_W'(1); o2n_wd = leaf_n;
         end
         S_SP4: begin
            par_we = 1'b1;  par_wa = esc_ff;  par_wd = aux;
            nord_we = 1'b1; nord_wa = esc_ff; nord_wd = eord_ff - NODE_W'(2);
            o2n_we = 1'b1;  o2n_wa = eord_ff - NODE_W'(2); o2n_wd = esc_ff;
            leaf_we = 1'b1; leaf_wd = leaf_n;
         end
         S_F1: begin
            lft_we = 1'b1;  lft_wa = ROOT_NODE; lft_wd = esc_ff;
            rgt_we = 1'b1;  rgt_wa = ROOT_NODE; rgt_wd = nfree_ff;
            par_we = 1'b1;  par_wa = esc_ff;    par_wd = ROOT_NODE;
            nord_we = 1'b1; nord_wa = esc_ff;   nord_wd = TOP_ORDER - NODE_W'(2);
            o2n_we = 1'b1;  o2n_wa = TOP_ORDER - NODE_W'(2); o2n_wd = esc_ff;
            wt_we = 1'b1;   wt_wa = nfree_ff;   wt_wd = WEIGHT_WIDTH'(1);
         end
         S_F2: begin
            par_we = 1'b1;  par_wa = nfree_ff; par_wd = ROOT_NODE;
            nord_we = 1'b1; nord_wa = nfree_ff; nord_wd = TOP_ORDER - NODE_W'(1);
            o2n_we = 1'b1;  o2n_wa = TOP_ORDER - NODE_W'(1); o2n_wd = nfree_ff;
            leaf_we = 1'b1; leaf_wd = nfree_ff;
         end
         S_U0: begin
            wt_ra = node_ff; nord_ra = node_ff; par_ra = node_ff;
         end
         S_SC:   o2n_ra = i_ff;
         S_SC2:  wt_ra = o2n_q;
         S_SW0:  par_ra = bnode_ff;
         S_SW1: begin
            rgt_ra = pn_ff; lft_ra = pn_ff;
         end
         S_SW2:  rgt_ra = pb_ff;
         S_SW3: begin
            if (pn_ff == pb_ff) begin
               lft_we = 1'b1; lft_wa = pn_ff; lft_wd = ra_ff;
               rgt_we = 1'b1; rgt_wa = pn_ff; rgt_wd = la_ff;
            end else if (ra_ff == node_ff) begin
               rgt_we = 1'b1; rgt_wa = pn_ff; rgt_wd = bnode_ff;
            end else begin
               lft_we = 1'b1; lft_wa = pn_ff; lft_wd = bnode_ff;
            end
            par_we = 1'b1;  par_wa = node_ff;  par_wd = pb_ff;
            nord_we = 1'b1; nord_wa = node_ff; nord_wd = best_ff;
            o2n_we = 1'b1;  o2n_wa = best_ff;  o2n_wd = node_ff;
         end
         S_SW4: begin
            if (pn_ff != pb_ff) begin
               if (rb_ff == bnode_ff) begin
                  rgt_we = 1'b1; rgt_wa = pb_ff; rgt_wd = node_ff;
               end else begin
                  lft_we = 1'b1; lft_wa = pb_ff; lft_wd = node_ff;
               end
            end
            par_we = 1'b1;  par_wa = bnode_ff;  par_wd = pn_ff;
            nord_we = 1'b1; nord_wa = bnode_ff; nord_wd = ord_ff;
            o2n_we = 1'b1;  o2n_wa = ord_ff;    o2n_wd = bnode_ff;
         end
         S_INC: begin
            wt_we = 1'b1; wt_wa = node_ff; wt_wd = w_ff + WEIGHT_WIDTH'(1);
         end
         default: ;
      endcase
   end

   // memories, registered read data
   always_ff @(posedge clock) begin
      if (wt_we)   wt_mem[wt_wa]     <= wt_wd;
      if (par_we)  par_mem[par_wa]   <= par_wd;
      if (lft_we)  lft_mem[lft_wa]   <= lft_wd;
      if (rgt_we)  rgt_mem[rgt_wa]   <= rgt_wd;
      if (nord_we) nord_mem[nord_wa] <= nord_wd;
      if (o2n_we)  o2n_mem[o2n_wa]   <= o2n_wd;
      if (leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
      if (stk_we)  stk_mem[stk_wa]   <= stk_wd;
      wt_q   <= wt_mem[wt_ra];
      par_q  <= par_mem[par_ra];
      lft_q  <= lft_mem[lft_ra];
      rgt_q  <= rgt_mem[rgt_ra];
      nord_q <= nord_mem[nord_ra];
      o2n_q  <= o2n_mem[o2n_ra];
      leaf_q <= leaf_mem[leaf_ra];
      stk_q  <= stk_mem[depth_ff[PATH_W-1:0]];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         mode_ff  <= M_OLD;
         rootw_ff <= WEIGHT_WIDTH'(1);
         esc_ff   <= ESC_INIT;
         nfree_ff <= NFREE_INIT;
         first_ff <= 1'b0;
         seen_ff  <= '0;
         end_ff   <= 1'b0;
      end else begin
         unique case (st_ff)
            S_IDLE: begin
               if (req.valid) begin
                  sym_ff   <= req.in_byte;
                  end_ff   <= req.is_end;
                  depth_ff <= '0;
                  node_ff  <= esc_ff;
                  if (req.is_end) begin
                     mode_ff <= M_END;
                     st_ff   <= first_ff ? S_WP : S_ER;
                  end else if ({1'b0, req.in_byte} >= ALPHA_LIM) begin
                     st_ff <= S_IDLE;
                  end else if (seen_ff[req.in_byte]) begin
                     mode_ff <= M_OLD;
                     st_ff   <= S_LEAF;
                  end else if (!first_ff) begin
                     mode_ff <= M_FIRST;
                     st_ff   <= node_bad(nfree_ff) ? S_IDLE : S_F1;
                  end else begin
                     mode_ff <= M_NEW;
                     st_ff   <= node_bad(leaf_n) ? S_IDLE : S_EORD;
                  end
               end
            end
            S_LEAF: begin
               node_ff <= leaf_q;
               lf_ff   <= leaf_q;
               st_ff   <= S_WP;
            end
            S_EORD: begin
               eord_ff <= nord_q;
               st_ff   <= (nord_q < NODE_W'(2) || node_bad(nord_q)) ? S_IDLE : S_WP;
            end
            S_WP: begin
               if (node_ff == ROOT_NODE || node_bad(node_ff) || depth_ff == PATH_LIM) begin
                  unique case (mode_ff)
                     M_OLD: begin
                        node_ff <= lf_ff;
                        st_ff   <= S_UST;
                     end
                     M_NEW:   st_ff <= S_SP0;
                     default: st_ff <= S_ER;
                  endcase
               end else begin
                  st_ff <= S_WP2;
               end
            end
            S_WP2: begin
               pnode_ff <= par_q;
               if (node_bad(par_q)) begin
                  unique case (mode_ff)
                     M_OLD: begin
                        node_ff <= lf_ff;
                        st_ff   <= S_UST;
                     end
                     M_NEW:   st_ff <= S_SP0;
                     default: st_ff <= S_ER;
                  endcase
               end else begin
                  st_ff <= S_WR;
               end
            end
            S_WR: begin
               depth_ff <= depth_ff + (PATH_W+1)'(1);
               node_ff  <= pnode_ff;
               st_ff    <= S_WP;
            end
            S_SP0: st_ff <= S_SP1;
            S_SP1: begin
               pnode_ff <= par_q;
               st_ff    <= S_SP2;
            end
            S_SP2: st_ff <= S_SP3;
            S_SP3: st_ff <= S_SP4;
            S_SP4: begin
               seen_ff[sym_ff] <= 1'b1;
               nfree_ff        <= leaf_n + NODE_W'(1);
               node_ff         <= aux;
               st_ff           <= S_UST;
            end
            S_F1: st_ff <= S_F2;
            S_F2: begin
               seen_ff[sym_ff] <= 1'b1;
               nfree_ff        <= nfree_ff + NODE_W'(1);
               first_ff        <= 1'b1;
               st_ff           <= S_ER;
            end
            S_UST: begin
               guard_ff <= '0;
               st_ff    <= (rootw_ff == WMAX) ? S_ER : S_U0;
            end
            S_U0: begin
               if (node_ff == ROOT_NODE || node_bad(node_ff) || guard_ff >= NODE_LIM) begin
                  rootw_ff <= rootw_ff + WEIGHT_WIDTH'(1);
                  st_ff    <= S_ER;
               end else begin
                  st_ff <= S_U1;
               end
            end
            S_U1: begin
               w_ff    <= wt_q;
               ord_ff  <= nord_q;
               best_ff <= nord_q;
               pn_ff   <= par_q;
               i_ff    <= nord_q + NODE_W'(1);
               st_ff   <= S_SC;
            end
            S_SC:  st_ff <= (i_ff >= TOP_ORDER) ? S_DEC : S_SC2;
            S_SC2: begin
               mnode_ff <= o2n_q;
               st_ff    <= node_bad(o2n_q) ? S_DEC : S_SC3;
            end
            S_SC3: begin
               if (wt_q != w_ff) begin
                  st_ff <= S_DEC;
               end else begin
                  if (mnode_ff != pn_ff) begin
                     best_ff  <= i_ff;
                     bnode_ff <= mnode_ff;
                  end
                  i_ff  <= i_ff + NODE_W'(1);
                  st_ff <= S_SC;
               end
            end
            S_DEC: st_ff <= (best_ff > ord_ff) ? S_SW0 : S_INC;
            S_SW0: st_ff <= S_SW1;
            S_SW1: begin
               pb_ff <= par_q;
               st_ff <= S_SW2;
            end
            S_SW2: begin
               ra_ff <= rgt_q;
               la_ff <= lft_q;
               st_ff <= S_SW3;
            end
            S_SW3: begin
               rb_ff <= rgt_q;
               st_ff <= S_SW4;
            end
            S_SW4: begin
               pn_ff <= pb_ff;   // node now hangs under the partner's old parent
               st_ff <= S_INC;
            end
            S_INC: begin
               node_ff  <= pn_ff;
               guard_ff <= guard_ff + (NODE_W+1)'(1);
               st_ff    <= S_U0;
            end
            S_ER: begin
               if (depth_ff == '0) begin
                  k_ff  <= 3'd7;
                  st_ff <= raw_mode ? S_RAW : S_FIN;
               end else begin
                  depth_ff <= depth_ff - (PATH_W+1)'(1);
                  st_ff    <= S_EW;
               end
            end
            S_EW: st_ff <= S_EB;
            S_EB: if (tok_ready) st_ff <= S_ER;
            S_RAW: begin
               if (tok_ready) begin
                  k_ff  <= k_ff - 3'd1;
                  st_ff <= (k_ff == 3'd0) ? S_FIN : S_RAW;
               end
            end
            S_FIN: if (tok_ready) st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== design/fgk_packer.sv =====
// Bit packer: gathers bits MSB first, holds one byte back to flag the last one,
// pads on flush and drives the result register. Depends on fgk_pkg, fgk_rsp_if.
`default_nettype none
module fgk_packer
   import fgk_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire fgk_tok_type tok,
   output logic             tok_ready,
   fgk_rsp_if.source        rsp
);
   typedef enum logic [1:0] {P_ACC, P_PAD, P_FIN} pstate_type;

   pstate_type st_ff;
   logic [7:0] pbits_ff, held_ff, out_ff;
   logic [2:0] pcnt_ff;
   logic       held_v_ff, rsp_v_ff, last_ff, done_ff, ovfo_ff, ovf_ff, flush_ff;
   logic       outfree, push, pbit, full, stall, ovf_now, emit;
   logic [7:0] nb;

   assign outfree   = !rsp_v_ff || rsp.ready;
   assign push      = (st_ff == P_ACC && tok.valid && !tok.fin) || (st_ff == P_PAD);
   assign pbit      = (st_ff == P_ACC) ? tok.bit_val : 1'b0;
   assign full      = (pcnt_ff == 3'd7);
   assign nb        = {pbits_ff[6:0], pbit};
   assign stall     = full && held_v_ff && !outfree;
   assign tok_ready = (st_ff == P_ACC) && (tok.fin || !stall);
   assign ovf_now   = (st_ff == P_ACC) ? tok.ovf : ovf_ff;
   // result register loads either a displaced held byte or the final byte
   assign emit      = (push && !stall && full && held_v_ff) ||
                      (st_ff == P_FIN && held_v_ff && outfree);

   assign rsp.valid       = rsp_v_ff;
   assign rsp.out_byte    = out_ff;
   assign rsp.last        = last_ff;
   assign rsp.stream_done = done_ff;
   assign rsp.overflow    = ovfo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= P_ACC;
         pcnt_ff   <= '0;
         pbits_ff  <= '0;
         held_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         if (emit) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_v_ff <= 1'b0;
         end
         if (push && !stall) begin
            if (full) begin
               if (held_v_ff) begin
                  out_ff   <= held_ff;
                  last_ff  <= 1'b0;
                  done_ff  <= 1'b0;
                  ovfo_ff  <= ovf_now;
               end
               held_ff   <= nb;
               held_v_ff <= 1'b1;
               pbits_ff  <= '0;
               pcnt_ff   <= '0;
            end else begin
               pbits_ff <= nb;
               pcnt_ff  <= pcnt_ff + 3'd1;
            end
         end
         unique case (st_ff)
            P_ACC: begin
               if (tok.valid && tok_ready) begin
                  ovf_ff <= tok.ovf;
                  if (tok.fin) begin
                     flush_ff <= tok.flush;
                     st_ff    <= tok.flush ? P_PAD : P_FIN;
                  end
               end
            end
            P_PAD: if (full && !stall) st_ff <= P_FIN;
            P_FIN: begin
               if (!held_v_ff) begin
                  st_ff <= P_ACC;
               end else if (outfree) begin
                  out_ff    <= held_ff;
                  last_ff   <= 1'b1;
                  done_ff   <= flush_ff;
                  ovfo_ff   <= ovf_ff;
                  held_v_ff <= 1'b0;
                  st_ff     <= P_ACC;
               end
            end
            default: st_ff <= P_ACC;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== bench/fgk_bench_if.sv =====
// Bench-side note: channel interfaces come from the design (fgk_req_if, fgk_rsp_if).
// This file holds the bench's shared types; no dependencies.
`timescale 1ns / 100ps
package fgk_bench_pkg;
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       stream_done;
      logic       overflow;
   } code_byte_type;
endpackage

// ===== bench/fgk_checker.sv =====
// Checker: watches both channels, models the FGK tree, compares every code byte.
// Depends on fgk_pkg, fgk_bench_pkg and the design's channel interfaces.
`timescale 1ns / 100ps
module fgk_checker
   import fgk_pkg::*;
   import fgk_bench_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   fgk_req_if        req,
   fgk_rsp_if        rsp,
   output int        fail_count,
   output int        pending_bytes,
   output int        bytes_seen
);
   localparam int KIND_INTERNAL = 'h100;
   localparam int KIND_ESCAPE   = 'h101;
   localparam int KIND_ROOT     = 'h102;
   localparam int TOP           = NODE_COUNT - 1;

   logic [WEIGHT_WIDTH-1:0] wt [NODE_COUNT];
   int par [NODE_COUNT], lft [NODE_COUNT], rgt [NODE_COUNT];
   int ord [NODE_COUNT], at_ord [NODE_COUNT];
   int leaf_of [ALPHABET_SIZE];
   bit seen [ALPHABET_SIZE];
   int esc, nfree;
   bit started;
   logic [7:0] acc;
   int acc_n;
   code_byte_type code_q [$];
   int item_start;

   function automatic void tree_init();
      for (int i = 0; i < NODE_COUNT; i++) begin
         wt[i] = '0; par[i] = 0; lft[i] = 0; rgt[i] = 0; ord[i] = 0; at_ord[i] = 0;
      end
      for (int s = 0; s < ALPHABET_SIZE; s++) begin
         leaf_of[s] = 0; seen[s] = 0;
      end
      wt[0] = WEIGHT_WIDTH'(1); ord[0] = TOP; at_ord[TOP] = 0;
      esc = 1; nfree = 2; started = 0; acc = '0; acc_n = 0;
   endfunction

   function automatic void put_bit(bit b);
      code_byte_type c;
      acc = {acc[6:0], b};
      acc_n++;
      if (acc_n == 8) begin
         c = '{out_byte: acc, last: 0, stream_done: 0, overflow: 0};
         code_q.insert(code_q.size(), c);
         acc = '0; acc_n = 0;
      end
   endfunction

   function automatic void put_path(int n);
      bit stk [$];
      int p;
      while (n != 0 && stk.size() < PATH_DEPTH) begin
         p = par[n];
         stk.push_front(rgt[p] == n);
         n = p;
      end
      foreach (stk[i]) put_bit(stk[i]);
   endfunction

   function automatic void swap_pair(int a, int b);
      int pa, pb, oa, ob, t;
      pa = par[a]; pb = par[b]; oa = ord[a]; ob = ord[b];
      if (pa == pb) begin
         t = lft[pa]; lft[pa] = rgt[pa]; rgt[pa] = t;
      end else begin
         if (rgt[pa] == a) rgt[pa] = b; else lft[pa] = b;
         if (rgt[pb] == b) rgt[pb] = a; else lft[pb] = a;
      end
      par[a] = pb; par[b] = pa; ord[a] = ob; ord[b] = oa;
      at_ord[ob] = a; at_ord[oa] = b;
   endfunction

   function automatic void bump_weights(int n);
      int best, m;
      if (wt[0] == WMAX) return;
      while (n != 0) begin
         best = ord[n];
         for (int i = ord[n] + 1; i < TOP; i++) begin
            m = at_ord[i];
            if (wt[m] != wt[n]) break;
            if (m != par[n]) best = i;
         end
         if (best > ord[n]) swap_pair(n, at_ord[best]);
         wt[n] = wt[n] + 1'b1;
         n = par[n];
      end
      wt[0] = wt[0] + 1'b1;
   endfunction

   // Encode one transaction; appends its code bytes and fixes up the flags.
   function automatic void encode_item(logic [7:0] sym, logic fin);
      int aux, lf, eo, p;
      item_start = code_q.size();
      if (fin) begin
         if (started) put_path(esc);
         for (int k = 8 - acc_n; k > 0; k--) put_bit(0);
         code_q[code_q.size()-1].stream_done = 1;
      end else if (seen[sym]) begin
         put_path(leaf_of[sym]);
         bump_weights(leaf_of[sym]);
      end else if (!started) begin
         for (int k = 7; k >= 0; k--) put_bit(sym[k]);
         lf = nfree;
         lft[0] = esc; rgt[0] = lf; par[esc] = 0;
         ord[esc] = TOP - 2; at_ord[TOP-2] = esc;
         par[lf] = 0; wt[lf] = WEIGHT_WIDTH'(1); ord[lf] = TOP - 1; at_ord[TOP-1] = lf;
         leaf_of[sym] = lf; seen[sym] = 1; nfree = lf + 1; started = 1;
      end else begin
         aux = nfree; lf = nfree + 1;
         if (lf >= NODE_COUNT) return;
         eo = ord[esc];
         if (eo < 2) return;
         put_path(esc);
         for (int k = 7; k >= 0; k--) put_bit(sym[k]);
         p = par[esc];
         if (rgt[p] == esc) rgt[p] = aux; else lft[p] = aux;
         par[aux] = p; lft[aux] = esc; rgt[aux] = lf; wt[aux] = '0;
         ord[aux] = eo; at_ord[eo] = aux;
         par[lf] = aux; wt[lf] = WEIGHT_WIDTH'(1); ord[lf] = eo - 1; at_ord[eo-1] = lf;
         par[esc] = aux; ord[esc] = eo - 2; at_ord[eo-2] = esc;
         leaf_of[sym] = lf; seen[sym] = 1; nfree = lf + 1;
         bump_weights(aux);
      end
      for (int k = item_start; k < code_q.size(); k++) code_q[k].overflow = (wt[0] == WMAX);
      if (code_q.size() > item_start) code_q[code_q.size()-1].last = 1;
   endfunction

   task automatic report(string what, logic [7:0] got, logic [7:0] want);
      $display("MISMATCH %s at %0t: got %0h, want %0h", what, $time, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      code_byte_type want;
      if (reset) begin
         tree_init();
         code_q.delete();
         fail_count = 0;
         bytes_seen = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            bytes_seen = bytes_seen + 1;
            if (code_q.size() == 0) begin
               report("unexpected byte", rsp.out_byte, 8'h00);
            end else begin
               want = code_q.pop_front();
               if (rsp.out_byte !== want.out_byte) report("out_byte", rsp.out_byte, want.out_byte);
               if (rsp.last !== want.last) report("last", 8'(rsp.last), 8'(want.last));
               if (rsp.stream_done !== want.stream_done)
                  report("stream_done", 8'(rsp.stream_done), 8'(want.stream_done));
               if (rsp.overflow !== want.overflow)
                  report("overflow", 8'(rsp.overflow), 8'(want.overflow));
            end
         end
         if (req.valid && req.ready) encode_item(req.in_byte, req.is_end);
      end
      pending_bytes = code_q.size();
   end
endmodule

// ===== bench/testbench.sv =====
// Top of the encoder bench: clock, reset, stimulus and verdict.
// Depends on fgk_pkg, the channel interfaces, fgk_checker and the encoder top.
`timescale 1ns / 100ps
module testbench;
   import fgk_pkg::*;

   localparam int NUM_RANDOM  = 385;
   localparam int CYCLE_LIMIT = 4000000;

   logic clock;
   logic reset;
   int   fail_count, pending_bytes, bytes_seen;
   int   cycle_count;
   int   items_sent, ends_sent;
   bit   idle_free;      // final stretch: no gaps on either side
   bit   hold_rsp;       // long receiver hold-off to back the block up

   fgk_req_if req ();
   fgk_rsp_if rsp ();

   adaptive_huffman_encoder_top u_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   fgk_checker u_chk (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .pending_bytes(pending_bytes), .bytes_seen(bytes_seen)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Watchdog: generous bound on a slow but correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("adaptive_huffman_encoder_top test failed");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus the forced hold-off.
   initial begin
      int gap;
      rsp.ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_rsp) begin
            rsp.ready <= 0;
            @(posedge clock);
         end else if (!idle_free && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            rsp.ready <= 0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp.ready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Hold the receiver off for a long while once the sender is busy.
   initial begin
      hold_rsp = 0;
      wait (items_sent == 40);
      hold_rsp = 1;
      repeat (3000) @(posedge clock);
      hold_rsp = 0;
   end

   // Drive one transaction and wait for it to be taken.
   task automatic send_item(logic [7:0] sym, logic fin);
      req.valid   <= 1;
      req.in_byte <= sym;
      req.is_end  <= fin;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      items_sent++;
      if (fin) ends_sent++;
      if (!idle_free && $urandom_range(0, 4) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   initial begin
      int   r;
      logic [7:0] s;
      req.valid   = 0;
      req.in_byte = '0;
      req.is_end  = 0;
      reset       = 1;
      cycle_count = 0;
      items_sent  = 0;
      ends_sent   = 0;
      idle_free   = 0;
      repeat (6) @(posedge clock);
      reset <= 0;

      // Directed: end before any symbol, raw first symbol, escape splits,
      // repeats that force swaps, extreme bytes, end mid-byte, restart after end.
      send_item(8'hA5, 1);
      send_item(8'h00, 0);
      send_item(8'hFF, 0);
      send_item(8'h00, 0);
      send_item(8'h00, 0);
      send_item(8'hFF, 0);
      send_item(8'h80, 0);
      send_item(8'h01, 0);
      send_item(8'h7F, 0);
      send_item(8'h80, 0);
      send_item(8'h00, 0);
      send_item(8'h00, 1);
      send_item(8'h01, 0);
      send_item(8'h55, 0);
      send_item(8'hAA, 0);
      send_item(8'h55, 0);
      send_item(8'hFF, 1);
      send_item(8'hFF, 1);
      send_item(8'hAA, 0);
      send_item(8'h01, 0);

      // Random: skewed symbol mix so the tree both grows and rebalances often.
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM - 60) idle_free = 1;
         r = $urandom_range(0, 99);
         if (r < 4)       send_item(8'($urandom), 1);
         else if (r < 55) send_item(8'($urandom_range(0, 7)), 0);
         else if (r < 75) send_item(8'hF8 | 8'($urandom_range(0, 7)), 0);
         else begin
            s = 8'($urandom);
            send_item(s, 0);
         end
      end
      send_item(8'h00, 1);
      req.valid <= 0;

      wait (pending_bytes == 0);
      repeat (2000) @(posedge clock);

      $display("%0d transactions sent (%0d stream ends), %0d code bytes checked",
               items_sent, ends_sent, bytes_seen);
      if (fail_count == 0) begin
         $display("adaptive_huffman_encoder_top test passed");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("adaptive_huffman_encoder_top test failed");
      end
      $finish;
   end
endmodule
